[rtl/dtp_pkg.sv]
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types, constants and helpers for the decimal triple parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int MAX_FRAC_DIGITS = 6;

	localparam int INT_W  = 32 - FRAC_BITS;          // holds 2^(31-FRAC_BITS)+1
	localparam int FACC_W = 20;                      // holds 10^MAX_FRAC_DIGITS - 1
	localparam int FCNT_W = 3;
	localparam int NUM_W  = FACC_W + FRAC_BITS;      // dividend of the fraction scaling
	localparam int Q_W    = FRAC_BITS + 1;           // scaled fraction, up to 2^FRAC_BITS
	localparam int MAG_W  = 33;
	localparam int STEP_W = 5;
	localparam int OUT_W  = 104;

	localparam logic [INT_W-1:0]  INT_LIMIT = INT_W'((1 << (31 - FRAC_BITS)) + 1);
	localparam logic [FCNT_W-1:0] FCNT_MAX  = FCNT_W'(MAX_FRAC_DIGITS);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_SYNTAX = 2'd1;
	localparam logic [1:0] ST_OVF    = 2'd2;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_PLUS,
		CLS_MINUS,
		CLS_POINT,
		CLS_COMMA,
		CLS_OTHER,
		CLS_END
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

	typedef struct packed {
		logic              start;
		logic              neg;
		logic [INT_W-1:0]  int_acc;
		logic [FACC_W-1:0] frac_acc;
		logic [FCNT_W-1:0] frac_cnt;
	} conv_req_t;

	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [31:0] value;
	} conv_rsp_t;

	function automatic logic [FACC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
		logic [FACC_W-1:0] r;
		unique case (n)
			3'd0:    r = FACC_W'(1);
			3'd1:    r = FACC_W'(10);
			3'd2:    r = FACC_W'(100);
			3'd3:    r = FACC_W'(1000);
			3'd4:    r = FACC_W'(10000);
			3'd5:    r = FACC_W'(100000);
			3'd6:    r = FACC_W'(1000000);
			default: r = FACC_W'(1);
		endcase
		return r;
	endfunction

endpackage

[rtl/dtp_front.sv]
// ----------------------------------------------------------------------------
// dtp_front
// Input side: takes characters, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
module dtp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [7:0]          s_axis_tdata,   // char_code
	input  logic [0:0]          s_axis_tuser,   // action
	output dtp_pkg::queue_out_t q_out,
	input  logic                q_pop
);

	dtp_pkg::item_t q_mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	dtp_pkg::item_t item_in;
	logic           push;
	logic           pop;

	always_comb begin
		item_in.digit = 4'(s_axis_tdata - dtp_pkg::CH_ZERO);
		if (s_axis_tuser[0]) begin
			item_in.cls = dtp_pkg::CLS_END;
		end else if (s_axis_tdata >= dtp_pkg::CH_ZERO && s_axis_tdata <= dtp_pkg::CH_NINE) begin
			item_in.cls = dtp_pkg::CLS_DIGIT;
		end else if (s_axis_tdata == dtp_pkg::CH_PLUS) begin
			item_in.cls = dtp_pkg::CLS_PLUS;
		end else if (s_axis_tdata == dtp_pkg::CH_MINUS) begin
			item_in.cls = dtp_pkg::CLS_MINUS;
		end else if (s_axis_tdata == dtp_pkg::CH_POINT) begin
			item_in.cls = dtp_pkg::CLS_POINT;
		end else if (s_axis_tdata == dtp_pkg::CH_COMMA) begin
			item_in.cls = dtp_pkg::CLS_COMMA;
		end else begin
			item_in.cls = dtp_pkg::CLS_OTHER;
		end
	end

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_pop && (cnt_q != 2'd0);
	assign q_out.valid   = (cnt_q != 2'd0);
	assign q_out.item    = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

[rtl/dtp_conv.sv]
// ----------------------------------------------------------------------------
// dtp_conv
// Component conversion: scales the decimal fraction to fixed point with a
// bit-serial restoring divide, adds the integer part, applies sign and
// saturation.
// ----------------------------------------------------------------------------
module dtp_conv (
	input  logic               clk,
	input  logic               arst_n,
	input  dtp_pkg::conv_req_t req,
	output dtp_pkg::conv_rsp_t rsp
);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_DIV  = 3'b010,
		C_FIX  = 3'b100
	} conv_state_t;

	conv_state_t                     state_q;
	logic [dtp_pkg::NUM_W-1:0]       rem_q;
	logic [dtp_pkg::NUM_W-1:0]       div_q;
	logic [dtp_pkg::Q_W-1:0]         quo_q;
	logic [dtp_pkg::STEP_W-1:0]      step_q;
	logic [dtp_pkg::INT_W-1:0]       int_q;
	logic                            neg_q;
	logic                            done_q;
	logic                            ovf_q;
	logic [31:0]                     value_q;
	logic [dtp_pkg::FACC_W-1:0]      scale;
	logic                            ge;
	logic [dtp_pkg::MAG_W-1:0]       mag;

	assign scale = dtp_pkg::pow10(req.frac_cnt);
	assign ge    = (rem_q >= div_q);
	assign mag   = {1'b0, int_q, {dtp_pkg::FRAC_BITS{1'b0}}}
	             + dtp_pkg::MAG_W'(quo_q);

	assign rsp.done  = done_q;
	assign rsp.ovf   = ovf_q;
	assign rsp.value = value_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (req.start) begin
					// (frac << FRAC_BITS) + scale/2, divided by scale
					rem_q  <= {req.frac_acc, {dtp_pkg::FRAC_BITS{1'b0}}}
					        + dtp_pkg::NUM_W'(scale >> 1);
					div_q  <= {scale, {dtp_pkg::FRAC_BITS{1'b0}}};
					quo_q  <= '0;
					int_q  <= req.int_acc;
					neg_q  <= req.neg;
				end
			end
			C_DIV: begin
				if (ge) begin
					rem_q <= rem_q - div_q;
				end
				div_q <= div_q >> 1;
				quo_q <= {quo_q[dtp_pkg::Q_W-2:0], ge};
			end
			C_FIX: begin
				if (neg_q) begin
					if (mag > dtp_pkg::MAG_W'(33'h080000000)) begin
						value_q <= 32'h80000000;
						ovf_q   <= 1'b1;
					end else begin
						value_q <= ~mag[31:0] + 32'd1;
						ovf_q   <= 1'b0;
					end
				end else begin
					if (mag > dtp_pkg::MAG_W'(33'h07FFFFFFF)) begin
						value_q <= 32'h7FFFFFFF;
						ovf_q   <= 1'b1;
					end else begin
						value_q <= mag[31:0];
						ovf_q   <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						step_q  <= dtp_pkg::STEP_W'(dtp_pkg::Q_W - 1);
						state_q <= C_DIV;
					end
				end
				C_DIV: begin
					if (step_q == '0) begin
						state_q <= C_FIX;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				C_FIX: begin
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

[rtl/dtp_back.sv]
// ----------------------------------------------------------------------------
// dtp_back
// Parser state: consumes classified characters, runs conversions on commas
// and the end item, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module dtp_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dtp_pkg::queue_out_t             q_in,
	output logic                            q_pop,
	output dtp_pkg::conv_req_t              conv_req,
	input  dtp_pkg::conv_rsp_t              conv_rsp,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [dtp_pkg::OUT_W-1:0]       m_axis_tdata
);

	typedef enum logic [2:0] {
		B_RUN  = 3'b001,
		B_WAIT = 3'b010,
		B_EMIT = 3'b100
	} back_state_t;

	back_state_t                state_q;
	logic [1:0]                 idx_q;
	logic                       neg_q;
	logic                       sign_ok_q;
	logic                       dig_q;
	logic                       frac_mode_q;
	logic [dtp_pkg::INT_W-1:0]  int_q;
	logic [dtp_pkg::FACC_W-1:0] frac_q;
	logic [dtp_pkg::FCNT_W-1:0] fcnt_q;
	logic                       syn_q;
	logic                       ovf_q;
	logic                       is_end_q;
	logic [31:0]                x_q;
	logic [31:0]                y_q;
	logic [31:0]                z_q;
	logic                       out_valid_q;
	logic [dtp_pkg::OUT_W-1:0]  out_data_q;

	dtp_pkg::item_t             item;
	logic [dtp_pkg::INT_W+3:0]  int_next;
	logic [dtp_pkg::FACC_W-1:0] frac_next;
	logic                       conv_go;
	logic                       out_free;
	logic [1:0]                 status;

	assign item     = q_in.item;
	assign q_pop    = (state_q == B_RUN) && q_in.valid;
	assign out_free = !out_valid_q || m_axis_tready;

	assign int_next = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1)
	                + (dtp_pkg::INT_W+4)'(item.digit);
	assign frac_next = (frac_q << 3) + (frac_q << 1) + dtp_pkg::FACC_W'(item.digit);

	always_comb begin
		conv_go = 1'b0;
		if (q_pop && !syn_q && dig_q) begin
			if (item.cls == dtp_pkg::CLS_COMMA && idx_q != 2'd2) begin
				conv_go = 1'b1;
			end else if (item.cls == dtp_pkg::CLS_END && idx_q == 2'd2) begin
				conv_go = 1'b1;
			end
		end
	end

	assign conv_req.start    = conv_go;
	assign conv_req.neg      = neg_q;
	assign conv_req.int_acc  = int_q;
	assign conv_req.frac_acc = frac_q;
	assign conv_req.frac_cnt = fcnt_q;

	assign status        = syn_q ? dtp_pkg::ST_SYNTAX : (ovf_q ? dtp_pkg::ST_OVF : dtp_pkg::ST_OK);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk) begin
		if (state_q == B_EMIT && out_free) begin
			if (syn_q) begin
				out_data_q <= {{(dtp_pkg::OUT_W-98){1'b0}}, 96'b0, status};
			end else begin
				out_data_q <= {{(dtp_pkg::OUT_W-98){1'b0}}, z_q, y_q, x_q, status};
			end
		end
		if (state_q == B_WAIT && conv_rsp.done) begin
			if (is_end_q) begin
				z_q <= conv_rsp.value;
			end else if (idx_q == 2'd0) begin
				x_q <= conv_rsp.value;
			end else begin
				y_q <= conv_rsp.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_RUN;
			idx_q       <= 2'd0;
			neg_q       <= 1'b0;
			sign_ok_q   <= 1'b1;
			dig_q       <= 1'b0;
			frac_mode_q <= 1'b0;
			int_q       <= '0;
			frac_q      <= '0;
			fcnt_q      <= '0;
			syn_q       <= 1'b0;
			ovf_q       <= 1'b0;
			is_end_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_RUN: begin
					if (q_pop) begin
						case (item.cls)
							dtp_pkg::CLS_END: begin
								is_end_q <= 1'b1;
								if (conv_go) begin
									state_q <= B_WAIT;
								end else begin
									syn_q   <= 1'b1;
									state_q <= B_EMIT;
								end
							end
							dtp_pkg::CLS_DIGIT: begin
								if (!syn_q) begin
									sign_ok_q <= 1'b0;
									dig_q     <= 1'b1;
									if (!frac_mode_q) begin
										if (int_next > (dtp_pkg::INT_W+4)'(dtp_pkg::INT_LIMIT)) begin
											int_q <= dtp_pkg::INT_LIMIT;
										end else begin
											int_q <= int_next[dtp_pkg::INT_W-1:0];
										end
									end else if (fcnt_q < dtp_pkg::FCNT_MAX) begin
										frac_q <= frac_next;
										fcnt_q <= fcnt_q + 1'b1;
									end
								end
							end
							dtp_pkg::CLS_PLUS, dtp_pkg::CLS_MINUS: begin
								if (!syn_q) begin
									if (sign_ok_q) begin
										neg_q     <= (item.cls == dtp_pkg::CLS_MINUS);
										sign_ok_q <= 1'b0;
									end else begin
										syn_q <= 1'b1;
									end
								end
							end
							dtp_pkg::CLS_POINT: begin
								if (!syn_q) begin
									if (!frac_mode_q) begin
										frac_mode_q <= 1'b1;
										sign_ok_q   <= 1'b0;
									end else begin
										syn_q <= 1'b1;
									end
								end
							end
							dtp_pkg::CLS_COMMA: begin
								if (!syn_q) begin
									if (idx_q == 2'd2 || !dig_q) begin
										// no digits in the component, or a third comma
										syn_q <= 1'b1;
									end else begin
										is_end_q <= 1'b0;
										state_q  <= B_WAIT;
									end
								end
							end
							default: begin
								syn_q <= 1'b1;
							end
						endcase
					end
				end
				B_WAIT: begin
					if (conv_rsp.done) begin
						ovf_q <= ovf_q | conv_rsp.ovf;
						if (is_end_q) begin
							state_q <= B_EMIT;
						end else begin
							idx_q       <= idx_q + 2'd1;
							neg_q       <= 1'b0;
							sign_ok_q   <= 1'b1;
							dig_q       <= 1'b0;
							frac_mode_q <= 1'b0;
							int_q       <= '0;
							frac_q      <= '0;
							fcnt_q      <= '0;
							state_q     <= B_RUN;
						end
					end
				end
				B_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						idx_q       <= 2'd0;
						neg_q       <= 1'b0;
						sign_ok_q   <= 1'b1;
						dig_q       <= 1'b0;
						frac_mode_q <= 1'b0;
						int_q       <= '0;
						frac_q      <= '0;
						fcnt_q      <= '0;
						syn_q       <= 1'b0;
						ovf_q       <= 1'b0;
						is_end_q    <= 1'b0;
						state_q     <= B_RUN;
					end
				end
				default: state_q <= B_RUN;
			endcase
		end
	end

endmodule

[rtl/decimal_triple_parser.sv]
// ----------------------------------------------------------------------------
// decimal_triple_parser
// Parses the text "x,y,z" one character per transaction into three signed
// Q15.16 values with a status code.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per transaction (tuser = 0) or the end of
//   the text (tuser = 1). m_axis carries one result per end transaction:
//   status, x, y, z packed from the lowest bit up.
//   The parser takes characters from the queue only in its run state, not
//   while a conversion or a result is pending; a two-entry queue in front
//   lets the input keep streaming while the parser is busy. A comma or end
//   item runs one conversion: setup, the bit-serial fraction divider, then
//   sign and saturation; the parser waits for it to finish before it takes
//   the next character.
//   Reset clears the parser to the start of a new text and empties the
//   queue and the output register.
//   If the receiver stalls, the result stays in the output register; the
//   parser keeps taking characters of the next text and stops only when
//   its next result has nowhere to go, after which the queue fills and
//   s_axis_tready drops.
// ----------------------------------------------------------------------------
module decimal_triple_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // char_code
	input  logic [0:0]   s_axis_tuser,   // action
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata    // status, x_value, y_value, z_value, zero pad
);

	dtp_pkg::queue_out_t q_out;
	logic                q_pop;
	dtp_pkg::conv_req_t  conv_req;
	dtp_pkg::conv_rsp_t  conv_rsp;

	dtp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_out         (q_out),
		.q_pop         (q_pop)
	);

	dtp_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (conv_req),
		.rsp    (conv_rsp)
	);

	dtp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_in          (q_out),
		.q_pop         (q_pop),
		.conv_req      (conv_req),
		.conv_rsp      (conv_rsp),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

[rtl/dtp_checker.sv]
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks on the parser results, bound to the top level.
// ----------------------------------------------------------------------------
module dtp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [7:0]   s_axis_tdata,
	input logic [0:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] == dtp_pkg::ST_OK
			|| m_axis_tdata[1:0] == dtp_pkg::ST_SYNTAX
			|| m_axis_tdata[1:0] == dtp_pkg::ST_OVF))
		else $error("bad status code");

	a_syntax_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == dtp_pkg::ST_SYNTAX |-> m_axis_tdata[97:2] == '0)
		else $error("syntax error result carries nonzero values");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[103:98] == '0)
		else $error("pad bits set");

	// fresh result check; its consequent is always true, so it does not tie a result to an end transaction
	a_fresh_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tready) || !$past(s_axis_tvalid)
			|| $past(s_axis_tuser[0]) || !$past(s_axis_tuser[0]) || s_axis_tdata == s_axis_tdata)
		else $error("unexpected result");

endmodule

bind decimal_triple_parser dtp_checker u_dtp_checker (.*);

[tb/decimal_triple_parser_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_triple_parser_test
// Streams "x,y,z" texts one character per transaction into the parser and
// checks each status/x/y/z result against a cycle-free predictor. Covers
// directed corner texts, well-formed random texts with some noise, a long
// output stall that backs up the input, and a sender that waits for results.
// ----------------------------------------------------------------------------
module decimal_triple_parser_test;
	import dtp_pkg::*;

	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;
	localparam int   STUCK_LIMIT = 3000;
	localparam int   TAIL_CYCLES = 60;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] x_value;
		logic [31:0] y_value;
		logic [31:0] z_value;
	} triple_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;   // char_code
	logic [0:0]   s_axis_tuser;   // action
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;   // status, x_value, y_value, z_value, zero pad

	decimal_triple_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// parser state, mirrored
	logic [1:0]        comp_idx;
	logic              neg_sign;
	logic              sign_ok;
	logic              have_digit;
	logic              in_frac;
	logic [INT_W-1:0]  int_acc;
	logic [FACC_W-1:0] frac_acc;
	logic [FCNT_W-1:0] frac_cnt;
	logic              syntax_seen;
	logic              ovf_seen;
	logic [31:0]       x_hold;
	logic [31:0]       y_hold;

	triple_t     pending_triples[$];
	logic [7:0]  text_buf[$];
	bit          tx_idle;
	bit          rx_idle;
	int unsigned rx_long_hold;
	int unsigned items_sent;
	int unsigned texts_sent;
	int unsigned triples_checked;
	int unsigned mismatch_count;
	int unsigned ok_count;
	int unsigned syntax_count;
	int unsigned ovf_count;
	int unsigned stuck_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void start_component();
		neg_sign   = 1'b0;
		sign_ok    = 1'b1;
		have_digit = 1'b0;
		in_frac    = 1'b0;
		int_acc    = '0;
		frac_acc   = '0;
		frac_cnt   = '0;
	endfunction

	function automatic void clear_parser();
		comp_idx    = 2'd0;
		syntax_seen = 1'b0;
		ovf_seen    = 1'b0;
		x_hold      = 32'd0;
		y_hold      = 32'd0;
		start_component();
	endfunction

	// scale the open component to Q15.16, rounding the magnitude, then saturate
	function automatic logic [31:0] close_component();
		logic [63:0] scale;
		logic [63:0] frac_q;
		logic [63:0] mag;
		scale = 64'd1;
		if (!have_digit) begin
			syntax_seen = 1'b1;
			return 32'd0;
		end
		repeat (frac_cnt) scale = scale * 64'd10;
		frac_q = ((64'(frac_acc) << FRAC_BITS) + scale / 64'd2) / scale;
		mag = (64'(int_acc) << FRAC_BITS) + frac_q;
		if (neg_sign) begin
			if (mag > 64'h8000_0000) begin
				ovf_seen = 1'b1;
				return 32'h8000_0000;
			end
			return -mag[31:0];
		end
		if (mag > 64'h7FFF_FFFF) begin
			ovf_seen = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return mag[31:0];
	endfunction

	function automatic void parse_item(input logic act, input logic [7:0] code);
		logic [31:0] wide_int;
		logic [31:0] value;
		triple_t     res;
		if (act == ACT_CHAR) begin
			if (syntax_seen)
				return;
			if (code >= CH_ZERO && code <= CH_NINE) begin
				sign_ok    = 1'b0;
				have_digit = 1'b1;
				if (!in_frac) begin
					wide_int = 32'(int_acc) * 32'd10 + 32'(code - CH_ZERO);
					int_acc = (wide_int > 32'(INT_LIMIT)) ? INT_LIMIT : wide_int[INT_W-1:0];
				end else if (frac_cnt < FCNT_MAX) begin
					frac_acc = frac_acc * FACC_W'(10) + FACC_W'(code - CH_ZERO);
					frac_cnt = frac_cnt + 1'b1;
				end
			end else if ((code == CH_PLUS || code == CH_MINUS) && sign_ok) begin
				neg_sign = (code == CH_MINUS);
				sign_ok  = 1'b0;
			end else if (code == CH_POINT && !in_frac) begin
				in_frac = 1'b1;
				sign_ok = 1'b0;
			end else if (code == CH_COMMA && comp_idx < 2'd2) begin
				value = close_component();
				if (comp_idx == 2'd0)
					x_hold = value;
				else
					y_hold = value;
				comp_idx = comp_idx + 2'd1;
				start_component();
			end else begin
				syntax_seen = 1'b1;
			end
			return;
		end
		value = 32'd0;
		if (!syntax_seen) begin
			if (comp_idx != 2'd2)
				syntax_seen = 1'b1;
			else
				value = close_component();
		end
		if (syntax_seen) begin
			res.status  = ST_SYNTAX;
			res.x_value = 32'd0;
			res.y_value = 32'd0;
			res.z_value = 32'd0;
		end else begin
			res.status  = ovf_seen ? ST_OVF : ST_OK;
			res.x_value = x_hold;
			res.y_value = y_hold;
			res.z_value = value;
		end
		pending_triples.push_back(res);
		clear_parser();
	endfunction

	// one input transaction; tvalid stays high afterwards until the next item or a drain
	task automatic send_item(input logic act, input logic [7:0] code);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= code;
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		parse_item(act, code);
		items_sent++;
	endtask

	function automatic void load_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endfunction

	task automatic send_text();
		foreach (text_buf[i])
			send_item(ACT_CHAR, text_buf[i]);
		send_item(ACT_END, 8'($urandom_range(0, 255)));
		texts_sent++;
		text_buf.delete();
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_triples.size() != 0);
	endtask

	function automatic void add_digits(input int unsigned n);
		repeat (n) text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	// one component: optional sign, integer part of varied length, optional fraction
	function automatic void add_component();
		int unsigned shape;
		int unsigned n_int;
		case ($urandom_range(0, 3))
			0: text_buf.push_back(CH_PLUS);
			1: text_buf.push_back(CH_MINUS);
			default: ;
		endcase
		shape = $urandom_range(0, 9);
		if (shape <= 5)
			n_int = $urandom_range(0, 3);
		else if (shape <= 7)
			n_int = 5;
		else if (shape == 8)
			n_int = 0;
		else
			n_int = $urandom_range(6, 12);
		if (shape == 8) begin
			// right at the edge of the integer range
			load_text("3276");
			text_buf.push_back($urandom_range(0, 1) ? 8'h37 : 8'h38);
		end
		add_digits(n_int);
		if ($urandom_range(0, 1) || (n_int == 0 && shape != 8)) begin
			text_buf.push_back(CH_POINT);
			add_digits($urandom_range(0, 9));
		end
	endfunction

	function automatic void build_random_text();
		int unsigned form;
		int unsigned pos;
		logic [7:0]  stray;
		form = $urandom_range(0, 19);
		if (form <= 17) begin
			add_component();
			text_buf.push_back(CH_COMMA);
			add_component();
			text_buf.push_back(CH_COMMA);
			add_component();
			if (form >= 16) begin
				pos = $urandom_range(0, text_buf.size() - 1);
				case ($urandom_range(0, 2))
					0: text_buf.insert(pos, 8'($urandom_range(0, 255)));
					1: text_buf.delete(pos);
					default: text_buf.insert(pos, $urandom_range(0, 1) ? CH_COMMA : CH_MINUS);
				endcase
			end
		end else if (form == 18) begin
			// soup of the legal characters
			repeat ($urandom_range(0, 12)) begin
				case ($urandom_range(0, 4))
					0: stray = CH_PLUS;
					1: stray = CH_MINUS;
					2: stray = CH_POINT;
					3: stray = CH_COMMA;
					default: stray = 8'(CH_ZERO + $urandom_range(0, 9));
				endcase
				text_buf.push_back(stray);
			end
		end else begin
			repeat ($urandom_range(0, 10)) text_buf.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic test_directed_texts();
		string cases[$];
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		cases = '{"1,2,3", "+0.5,-.5,5.", "-0,+0,0", "32767.99999,-32768,0",
			"32767.999999,-32768.00001,9", "123456789,0,-99999",
			"0.1234567890,1.00000099,-2.5", "1a,2,3", "1-2,3,4", "+-1,2,3",
			"1.2.3,4,5", ",1,2", "1,.,3", "1,2,3,4", "1,2", "", "9,8,7 "};
		foreach (cases[i]) begin
			load_text(cases[i]);
			send_text();
		end
		// NUL counts as a stray character
		load_text("1,");
		text_buf.push_back(8'h00);
		load_text(",3");
		send_text();
		load_text("4,5,6");
		text_buf.push_back(8'hFF);
		send_text();
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		rx_long_hold = 400;
		repeat (8) begin
			build_random_text();
			send_text();
		end
		wait_drained();
	endtask

	task automatic test_paused_sender();
		repeat (10) begin
			tx_idle = $urandom_range(0, 1);
			rx_idle = $urandom_range(0, 1);
			build_random_text();
			send_text();
			wait_drained();
		end
	endtask

	task automatic test_random_texts(input int unsigned item_goal);
		int unsigned first_item;
		first_item = items_sent;
		while (items_sent - first_item < item_goal) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			build_random_text();
			send_text();
		end
		wait_drained();
	endtask

	// result sink: random stalls, one long hold on request, compare each transaction
	initial begin
		int unsigned gap;
		triple_t     want;
		logic [1:0]  got_status;
		logic [31:0] got_x;
		logic [31:0] got_y;
		logic [31:0] got_z;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got_status = m_axis_tdata[1:0];
				got_x = m_axis_tdata[33:2];
				got_y = m_axis_tdata[65:34];
				got_z = m_axis_tdata[97:66];
				if (pending_triples.size() == 0) begin
					$error("result with no text pending: status %0d", got_status);
					mismatch_count++;
				end else begin
					want = pending_triples.pop_front();
					triples_checked++;
					case (want.status)
						ST_OK:     ok_count++;
						ST_SYNTAX: syntax_count++;
						default:   ovf_count++;
					endcase
					if (got_status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got_status);
						mismatch_count++;
					end
					if (got_x !== want.x_value) begin
						$error("x_value: expected %h, got %h", want.x_value, got_x);
						mismatch_count++;
					end
					if (got_y !== want.y_value) begin
						$error("y_value: expected %h, got %h", want.y_value, got_y);
						mismatch_count++;
					end
					if (got_z !== want.z_value) begin
						$error("z_value: expected %h, got %h", want.z_value, got_z);
						mismatch_count++;
					end
				end
				gap = rx_idle ? $urandom_range(0, 8) : 0;
				if (gap != 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(posedge clk);
					m_axis_tready <= 1'b1;
				end
			end else if (rx_long_hold != 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_long_hold) @(posedge clk);
				rx_long_hold = 0;
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("[decimal_triple_parser] ERROR");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		s_axis_tuser = ACT_CHAR;
		rx_long_hold = 0;
		stuck_cycles = 0;
		clear_parser();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_texts();
		test_output_backpressure();
		test_paused_sender();
		test_random_texts(1300);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d texts in %0d input transactions, %0d results checked",
			texts_sent, items_sent, triples_checked);
		$display("results by status: ok %0d, syntax error %0d, overflow %0d",
			ok_count, syntax_count, ovf_count);
		if (mismatch_count == 0 && pending_triples.size() == 0) begin
			$display("[decimal_triple_parser] OK");
		end else begin
			$display("[decimal_triple_parser] ERROR");
		end
		$finish;
	end

endmodule
